// File: design/stt_pkg.sv
package stt_pkg;

  localparam int unsigned MaxSourceBytes = 65536;
  // offsets and lengths stop here
  localparam logic [15:0] ValueCap =
      16'((MaxSourceBytes - 1 > 65535) ? 65535 : MaxSourceBytes - 1);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [4:0] KindIdent   = 5'd0;
  localparam logic [4:0] KindInteger = 5'd3;
  localparam logic [4:0] KindFloat   = 5'd4;
  localparam logic [4:0] KindPunct   = 5'd5;
  localparam logic [4:0] KindMinus   = 5'd6;
  localparam logic [4:0] KindArrow   = 5'd17;
  localparam logic [4:0] KindInvalid = 5'd18;
  localparam logic [4:0] KindEnd     = 5'd19;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  // up to two tokens from one accepted item
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } scan_out_t;

endpackage

// File: design/stt_scan.sv
module stt_scan import stt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output scan_out_t  scan_o
);

  typedef enum logic [2:0] {
    ModeIdle,
    ModeWord,
    ModeDigits,
    ModeFraction,
    ModeDash
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] start_q, start_d;
  logic [15:0] len_q, len_d;
  logic [3:0]  cands_q, cands_d;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v >= ValueCap) ? ValueCap : v + 16'd1;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd0:    r = 3'd3;
      2'd1:    r = 3'd2;
      2'd2:    r = 3'd3;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0:    r = "l";
          3'd1:    r = "e";
          3'd2:    r = "t";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0:    r = "f";
          3'd1:    r = "n";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    r = "i";
          3'd1:    r = "n";
          3'd2:    r = "t";
          default: r = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    r = "f";
          3'd1:    r = "l";
          3'd2:    r = "o";
          3'd3:    r = "a";
          3'd4:    r = "t";
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

  // drop keywords that cannot match once c is appended at position len
  function automatic logic [3:0] kw_narrow(input logic [3:0] cands, input logic [15:0] len,
                                           input logic [7:0] c);
    logic [3:0] r;
    for (int k = 0; k < 4; k++) begin
      r[k] = cands[k] && (len < 16'(kw_len(2'(k)))) && (kw_char(2'(k), len[2:0]) == c);
    end
    return r;
  endfunction

  function automatic logic [4:0] word_kind(input logic [3:0] cands, input logic [15:0] len);
    logic [4:0] r;
    r = KindIdent;
    for (int k = 3; k >= 0; k--) begin
      if (cands[k] && len == 16'(kw_len(2'(k)))) begin
        r = 5'(k + 1);
      end
    end
    return r;
  endfunction

  always_comb begin
    logic       handled, is_letter, is_digit, is_blank, pre_emit, post_emit;
    logic [4:0] punct_kind;
    logic       punct_hit;
    tok_t       pre_tok, post_tok;

    mode_d    = mode_q;
    pos_d     = pos_q;
    start_d   = start_q;
    len_d     = len_q;
    cands_d   = cands_q;
    handled   = 1'b0;
    pre_emit  = 1'b0;
    post_emit = 1'b0;
    pre_tok   = '0;
    post_tok  = '0;
    scan_o    = '0;

    is_letter = byte_i inside {["a":"z"], ["A":"Z"]};
    is_digit  = byte_i inside {["0":"9"]};
    is_blank  = byte_i inside {8'h20, [8'd9:8'd13]};

    punct_hit  = 1'b1;
    punct_kind = KindPunct;
    case (byte_i)
      "+":     punct_kind = KindPunct;
      "-":     punct_kind = KindMinus;
      "*":     punct_kind = KindPunct + 5'd2;
      "/":     punct_kind = KindPunct + 5'd3;
      ";":     punct_kind = KindPunct + 5'd4;
      ":":     punct_kind = KindPunct + 5'd5;
      "=":     punct_kind = KindPunct + 5'd6;
      "(":     punct_kind = KindPunct + 5'd7;
      ")":     punct_kind = KindPunct + 5'd8;
      "{":     punct_kind = KindPunct + 5'd9;
      "}":     punct_kind = KindPunct + 5'd10;
      ",":     punct_kind = KindPunct + 5'd11;
      default: punct_hit = 1'b0;
    endcase

    // finish or extend the token in progress
    case (mode_q)
      ModeWord: begin
        if (is_letter || is_digit || byte_i == "_") begin
          cands_d = kw_narrow(cands_q, len_q, byte_i);
          len_d   = sat_inc(len_q);
          handled = 1'b1;
        end else begin
          pre_emit = 1'b1;
          pre_tok  = '{kind: word_kind(cands_q, len_q), start: start_q, length: len_q,
                       last: 1'b0};
        end
      end
      ModeDigits: begin
        if (is_digit) begin
          len_d   = sat_inc(len_q);
          handled = 1'b1;
        end else if (byte_i == ".") begin
          len_d   = sat_inc(len_q);
          mode_d  = ModeFraction;
          handled = 1'b1;
        end else begin
          pre_emit = 1'b1;
          pre_tok  = '{kind: KindInteger, start: start_q, length: len_q, last: 1'b0};
        end
      end
      ModeFraction: begin
        if (is_digit) begin
          len_d   = sat_inc(len_q);
          handled = 1'b1;
        end else begin
          pre_emit = 1'b1;
          pre_tok  = '{kind: KindFloat, start: start_q, length: len_q, last: 1'b0};
        end
      end
      ModeDash: begin
        pre_emit = 1'b1;
        if (byte_i == ">") begin
          pre_tok = '{kind: KindArrow, start: start_q, length: 16'd2, last: 1'b0};
          mode_d  = ModeIdle;
          handled = 1'b1;
        end else begin
          pre_tok = '{kind: KindMinus, start: start_q, length: 16'd1, last: 1'b0};
        end
      end
      default: ;
    endcase

    // byte seen as if between tokens
    if (!handled) begin
      mode_d = ModeIdle;
      if (byte_i == 8'h00) begin
        post_emit = 1'b1;
        post_tok  = '{kind: KindEnd, start: pos_q, length: 16'd0, last: 1'b0};
      end else if (is_blank) begin
        post_emit = 1'b0;
      end else if (is_letter) begin
        mode_d  = ModeWord;
        start_d = pos_q;
        len_d   = 16'd1;
        cands_d = kw_narrow(4'hF, 16'd0, byte_i);
      end else if (is_digit) begin
        mode_d  = ModeDigits;
        start_d = pos_q;
        len_d   = 16'd1;
      end else if (byte_i == "-") begin
        mode_d  = ModeDash;
        start_d = pos_q;
        len_d   = 16'd1;
      end else if (punct_hit) begin
        post_emit = 1'b1;
        post_tok  = '{kind: punct_kind, start: pos_q, length: 16'd1, last: 1'b0};
      end else begin
        post_emit = 1'b1;
        post_tok  = '{kind: KindInvalid, start: pos_q, length: 16'd0, last: 1'b0};
      end
    end

    // end of source puts the scanner back to its reset state
    if (!handled && byte_i == 8'h00) begin
      mode_d  = ModeIdle;
      pos_d   = 16'd0;
      start_d = 16'd0;
      len_d   = 16'd0;
      cands_d = 4'hF;
    end else begin
      pos_d = sat_inc(pos_q);
    end

    if (pre_emit && post_emit) begin
      post_tok.last = 1'b1;
      scan_o.tok0   = pre_tok;
      scan_o.tok1   = post_tok;
      scan_o.count  = 2'd2;
    end else if (pre_emit) begin
      pre_tok.last = 1'b1;
      scan_o.tok0  = pre_tok;
      scan_o.count = 2'd1;
    end else if (post_emit) begin
      post_tok.last = 1'b1;
      scan_o.tok0   = post_tok;
      scan_o.count  = 2'd1;
    end
    if (!accept_i) begin
      scan_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pos_q   <= 16'd0;
      start_q <= 16'd0;
      len_q   <= 16'd0;
      cands_q <= 4'hF;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      cands_q <= cands_d;
    end
  end

endmodule

// File: design/stt_fifo.sv
module stt_fifo import stt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_out_t push_i,
  input  logic      pop_i,
  output logic      not_empty_o,
  output logic      almost_full_o,
  output tok_t      head_o
);

  tok_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoAw:0]   count_q;
  logic [FifoAw-1:0] wr_next;

  assign wr_next       = wr_q + FifoAw'(1);
  assign not_empty_o   = (count_q != '0);
  // room for two tokens is kept so any item can be taken
  assign almost_full_o = (count_q > (FifoAw + 1)'(FifoDepth - 2));
  assign head_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + FifoAw'(push_i.count);
      if (pop_i) begin
        rd_q <= rd_q + FifoAw'(1);
      end
      count_q <= count_q + (FifoAw + 1)'(push_i.count) - (FifoAw + 1)'(pop_i);
    end
  end

endmodule

// File: design/source_text_tokenizer.sv
// tokens: the scanner decides combinationally and each token is registered into the queue
// throughput: one byte per cycle while not stalled; a byte that yields two tokens fills two slots, popped one at a time
// a four-entry token queue sets the figure: bytes stall while fewer than two slots are free
// reset: asynchronous, active low; scanner idle at offset 0 and the queue empty
module source_text_tokenizer import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  source_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  logic      in_accept;
  logic      out_accept;
  logic      almost_full;
  scan_out_t scan;
  tok_t      head;

  // a byte goes in whenever the queue can absorb the worst case of two tokens
  assign in_stall_o = almost_full;
  assign in_accept  = in_valid_i && !almost_full;
  assign out_accept = out_valid_o && !out_stall_i;

  // per-byte scanner: state registers and the token decision
  stt_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (source_byte_i),
    .scan_o   (scan)
  );

  // result queue decouples token bursts from the consumer
  stt_fifo u_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (scan),
    .pop_i         (out_accept),
    .not_empty_o   (out_valid_o),
    .almost_full_o (almost_full),
    .head_o        (head)
  );

  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.length;
  assign last_of_run_o  = head.last;

endmodule
